// ----- rtl/mwra_pkg.sv -----
// mwra_pkg: shared types, codes and constants of the write-combining region allocator
// depends on nothing; used by mwra_ctrl, mwra_dp and mtrr_wc_region_allocator

package mwra_pkg;

	// table geometry
	localparam int ENTRY_COUNT = 16;
	localparam int ADDR_BITS   = 48;
	localparam int IDX_W       = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
	localparam int CNT_W       = $clog2(ENTRY_COUNT + 1);

	// field positions and fixed words of one range entry
	localparam int          VALID_BIT    = 11;
	localparam int          PAGE_BITS    = 12;
	localparam int          MIN_BASE_BIT = 20;
	localparam int          MAX_BASE_BIT = 36;
	localparam int          MIN_PHYS     = 36;
	localparam logic [63:0] VALID_MASK   = 64'h0000_0000_0000_0800;
	localparam logic [63:0] TYPE_WC      = 64'h0000_0000_0000_0001;
	localparam logic [63:0] TYPE_FIELD   = 64'h0000_0000_0000_00FF;

	// configuration register indexes
	localparam int          CFG_IDX_W = 2;
	localparam int          CFG_DAT_W = 6;
	localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGES_SUPP     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WC_SUPP         = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PHYS_ADDR_BITS  = 2'd3;

	typedef enum logic [1:0] {
		OP_SETUP   = 2'd0,
		OP_ENABLE  = 2'd1,
		OP_DISABLE = 2'd2,
		OP_COPY    = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_OK          = 4'd0,
		ST_BELOW_1M    = 4'd1,
		ST_ABOVE_36    = 4'd2,
		ST_UNDER_4K    = 4'd3,
		ST_NOT_POW2    = 4'd4,
		ST_MISALIGNED  = 4'd5,
		ST_UNSUPPORTED = 4'd6,
		ST_NO_WC       = 4'd7,
		ST_OVERLAP     = 4'd8,
		ST_NONE_FREE   = 4'd9
	} status_t;

	// request and response words
	typedef struct packed {
		logic [1:0]  op;
		logic [47:0] region_base;
		logic [47:0] region_size;
		logic [3:0]  entry;
		logic [3:0]  source_entry;
	} req_word_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [3:0]  assigned_entry;
		logic [63:0] base_word;
		logic [63:0] mask_word;
	} rsp_word_t;

	// controller to datapath commands
	typedef struct packed {
		logic             load_in;
		logic             check;
		logic             rd_en;
		logic             rd_scan;
		logic [IDX_W-1:0] rd_addr;
		logic             save_slot;
		logic             wr_en;
		logic             wr_setup;
		logic [IDX_W-1:0] wr_addr;
		logic             out_load;
		status_t          out_status;
		logic [3:0]       out_entry;
		logic             out_zero;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		op_t              op;
		status_t          chk_code;
		logic             ent_oob;
		logic [CNT_W-1:0] limit;
		logic             ev_valid;
		logic             ev_overlap;
		logic             out_free;
	} sts_t;

endpackage

// ----- rtl/mwra_ctrl.sv -----
// mwra_ctrl: sequencer of the allocator (check, entry scan, write back, response)
// depends on mwra_pkg; drives the command struct of mwra_dp

module mwra_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  mwra_pkg::sts_t       sts,
	output mwra_pkg::cmd_t       cmd
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_CHECK = 5'b00010,
		S_SCAN  = 5'b00100,
		S_WB    = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t                         state_q, state_d;
	logic [mwra_pkg::CNT_W-1:0]     rd_cnt_q, rd_cnt_d;
	logic                           ev_pend_q, ev_pend_d;
	logic [mwra_pkg::IDX_W-1:0]     ev_idx_q, ev_idx_d;
	logic                           found_q, found_d;
	logic [mwra_pkg::IDX_W-1:0]     slot_q, slot_d;
	mwra_pkg::status_t              code_q, code_d;
	logic [3:0]                     res_entry_q, res_entry_d;
	logic                           zero_q, zero_d;
	logic                           issue;

	assign req_stall = (state_q != S_IDLE);

	// next state and commands
	always_comb begin
		state_d     = state_q;
		rd_cnt_d    = rd_cnt_q;
		ev_pend_d   = 1'b0;
		ev_idx_d    = ev_idx_q;
		found_d     = found_q;
		slot_d      = slot_q;
		code_d      = code_q;
		res_entry_d = res_entry_q;
		zero_d      = zero_q;
		cmd         = '0;
		cmd.out_status = code_q;
		cmd.out_entry  = res_entry_q;
		cmd.out_zero   = zero_q;
		cmd.wr_addr    = slot_q;
		issue       = (rd_cnt_q < sts.limit);
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				if (sts.op == mwra_pkg::OP_SETUP) begin
					if (sts.chk_code != mwra_pkg::ST_OK) begin
						code_d      = sts.chk_code;
						res_entry_d = 4'd0;
						zero_d      = 1'b1;
						state_d     = S_DONE;
					end else begin
						rd_cnt_d = '0;
						found_d  = 1'b0;
						state_d  = S_SCAN;
					end
				end else if (sts.ent_oob) begin
					code_d      = mwra_pkg::ST_OK;
					res_entry_d = 4'd0;
					zero_d      = 1'b1;
					state_d     = S_DONE;
				end else begin
					// direct op: fetch the entry it acts on, or the source entry of a copy
					cmd.rd_en   = 1'b1;
					cmd.rd_scan = 1'b0;
					state_d     = S_WB;
				end
			end
			S_SCAN: begin
				// read one entry a cycle, judge it the cycle after
				cmd.rd_en   = issue;
				cmd.rd_scan = 1'b1;
				cmd.rd_addr = rd_cnt_q[mwra_pkg::IDX_W-1:0];
				if (issue) begin
					rd_cnt_d = rd_cnt_q + mwra_pkg::CNT_W'(1);
				end
				ev_pend_d = issue;
				ev_idx_d  = rd_cnt_q[mwra_pkg::IDX_W-1:0];
				priority if (ev_pend_q && sts.ev_valid && sts.ev_overlap) begin
					code_d      = mwra_pkg::ST_OVERLAP;
					res_entry_d = 4'd0;
					zero_d      = 1'b1;
					ev_pend_d   = 1'b0;
					state_d     = S_DONE;
				end else if (ev_pend_q && !sts.ev_valid && !found_q) begin
					found_d       = 1'b1;
					slot_d        = ev_idx_q;
					cmd.save_slot = 1'b1;
				end else if (!ev_pend_q && !issue) begin
					if (found_q) begin
						state_d = S_WB;
					end else begin
						code_d      = mwra_pkg::ST_NONE_FREE;
						res_entry_d = 4'd0;
						zero_d      = 1'b1;
						state_d     = S_DONE;
					end
				end else begin
					state_d = S_SCAN;
				end
			end
			S_WB: begin
				cmd.wr_en    = 1'b1;
				cmd.wr_setup = (sts.op == mwra_pkg::OP_SETUP);
				code_d       = mwra_pkg::ST_OK;
				res_entry_d  = (sts.op == mwra_pkg::OP_SETUP) ? 4'(slot_q) : 4'd0;
				zero_d       = 1'b0;
				state_d      = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rd_cnt_q    <= '0;
			ev_pend_q   <= 1'b0;
			ev_idx_q    <= '0;
			found_q     <= 1'b0;
			slot_q      <= '0;
			code_q      <= mwra_pkg::ST_OK;
			res_entry_q <= 4'd0;
			zero_q      <= 1'b1;
		end else begin
			state_q     <= state_d;
			rd_cnt_q    <= rd_cnt_d;
			ev_pend_q   <= ev_pend_d;
			ev_idx_q    <= ev_idx_d;
			found_q     <= found_d;
			slot_q      <= slot_d;
			code_q      <= code_d;
			res_entry_q <= res_entry_d;
			zero_q      <= zero_d;
		end
	end

	// setup write back only with a free entry in hand
	a_wb_has_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WB && sts.op == mwra_pkg::OP_SETUP) |-> found_q)
		else $error("setup write back without a free entry");

	// a pending judgement always follows a read
	a_pend_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		ev_pend_q |-> $past(cmd.rd_en))
		else $error("entry judged without a read");

	// scan counter never runs past the active entries
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (rd_cnt_q <= sts.limit))
		else $error("scan counter beyond active entries");

	// a granted entry lies among the active ones
	a_slot_active: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && code_q == mwra_pkg::ST_OK && sts.op == mwra_pkg::OP_SETUP)
		|-> (mwra_pkg::CNT_W'(slot_q) < sts.limit))
		else $error("granted entry outside active range");

endmodule

// ----- rtl/mwra_dp.sv -----
// mwra_dp: datapath of the allocator: config registers, entry table, checks, response register
// depends on mwra_pkg; steered by the command struct from mwra_ctrl

module mwra_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  mwra_pkg::req_word_t                  req,
	input  logic                                 cfg_we,
	input  logic [mwra_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mwra_pkg::CFG_DAT_W-1:0]       cfg_data,
	input  mwra_pkg::cmd_t                       cmd,
	output mwra_pkg::sts_t                       sts,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output mwra_pkg::rsp_word_t                  rsp
);

	// implemented address bits of a range word for a given physical width
	function automatic logic [63:0] impl_bits(input logic [5:0] w);
		int          wc;
		logic [63:0] b;
		wc = int'(w);
		if (wc < mwra_pkg::MIN_PHYS) wc = mwra_pkg::MIN_PHYS;
		if (wc > mwra_pkg::ADDR_BITS) wc = mwra_pkg::ADDR_BITS;
		for (int k = 0; k < 64; k++) begin
			b[k] = (k >= mwra_pkg::PAGE_BITS) && (k < wc);
		end
		return b;
	endfunction

	mwra_pkg::req_word_t             req_q;
	logic [4:0]                      ent_use_q;
	logic                            rng_sup_q;
	logic                            wc_sup_q;
	logic [5:0]                      pab_q;
	logic [63:0]                     bits_q, end_q, mask_q;
	logic [63:0]                     ent_base_q [mwra_pkg::ENTRY_COUNT];
	logic [63:0]                     ent_mask_q [mwra_pkg::ENTRY_COUNT];
	logic [mwra_pkg::ENTRY_COUNT-1:0] vld_q;
	logic [63:0]                     rd_base_q, rd_mask_q;
	logic                            rd_vld_q;
	logic [63:0]                     slot_base_q, slot_mask_q;
	logic [63:0]                     res_base_q, res_mask_q;
	logic                            rsp_valid_q;
	mwra_pkg::rsp_word_t             rsp_q;

	logic [47:0]                     base, size, sm1;
	logic [63:0]                     base64;
	logic [63:0]                     rd_b, rd_m, rb, rm;
	logic [63:0]                     new_b, new_m;
	logic [mwra_pkg::IDX_W-1:0]      ra, wa;
	mwra_pkg::status_t               chk;

	assign base   = req_q.region_base;
	assign size   = req_q.region_size;
	assign sm1    = size - 48'd1;
	assign base64 = 64'(base);

	// region checks, first failing one wins
	always_comb begin
		priority if (base[47:mwra_pkg::MIN_BASE_BIT] == '0) chk = mwra_pkg::ST_BELOW_1M;
		else if (base[47:mwra_pkg::MAX_BASE_BIT] != '0) chk = mwra_pkg::ST_ABOVE_36;
		else if (size[47:mwra_pkg::PAGE_BITS] == '0) chk = mwra_pkg::ST_UNDER_4K;
		else if ((size & sm1) != '0) chk = mwra_pkg::ST_NOT_POW2;
		else if ((base & sm1) != '0) chk = mwra_pkg::ST_MISALIGNED;
		else if (!rng_sup_q) chk = mwra_pkg::ST_UNSUPPORTED;
		else if (!wc_sup_q) chk = mwra_pkg::ST_NO_WC;
		else chk = mwra_pkg::ST_OK;
	end

	// read word of the entry table, never-written entries read as zero
	assign rd_b = rd_vld_q ? rd_base_q : '0;
	assign rd_m = rd_vld_q ? rd_mask_q : '0;
	assign rb   = rd_b & bits_q;
	assign rm   = rd_m & bits_q;

	assign ra = cmd.rd_scan ? cmd.rd_addr :
		((req_q.op == mwra_pkg::OP_COPY) ? mwra_pkg::IDX_W'(req_q.source_entry)
		                                 : mwra_pkg::IDX_W'(req_q.entry));
	assign wa = cmd.wr_setup ? cmd.wr_addr : mwra_pkg::IDX_W'(req_q.entry);

	// status toward the controller
	always_comb begin
		sts.op         = mwra_pkg::op_t'(req_q.op);
		sts.chk_code   = chk;
		sts.ent_oob    = (int'(req_q.entry) >= mwra_pkg::ENTRY_COUNT) ||
			(req_q.op == mwra_pkg::OP_COPY &&
			 int'(req_q.source_entry) >= mwra_pkg::ENTRY_COUNT);
		sts.limit      = (int'(ent_use_q) > mwra_pkg::ENTRY_COUNT) ?
			mwra_pkg::CNT_W'(mwra_pkg::ENTRY_COUNT) : mwra_pkg::CNT_W'(ent_use_q);
		sts.ev_valid   = rd_m[mwra_pkg::VALID_BIT];
		sts.ev_overlap = (rb < end_q) && ((rb + (~rm & bits_q)) >= base64);
		sts.out_free   = !rsp_valid_q || !rsp_stall;
	end

	// words written back to the entry
	always_comb begin
		new_b = rd_b;
		new_m = rd_m;
		if (cmd.wr_setup) begin
			new_b = (slot_base_q & ~bits_q & ~mwra_pkg::TYPE_FIELD) | (base64 & bits_q) |
				mwra_pkg::TYPE_WC;
			new_m = (slot_mask_q & ~bits_q) | (mask_q & bits_q) | mwra_pkg::VALID_MASK;
		end else begin
			unique case (mwra_pkg::op_t'(req_q.op))
				mwra_pkg::OP_ENABLE:  new_m = rd_m | mwra_pkg::VALID_MASK;
				mwra_pkg::OP_DISABLE: new_m = rd_m & ~mwra_pkg::VALID_MASK;
				mwra_pkg::OP_COPY:    new_m = rd_m;
				default:              new_m = rd_m;
			endcase
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_use_q <= 5'd8;
			rng_sup_q <= 1'b1;
			wc_sup_q  <= 1'b1;
			pab_q     <= 6'd36;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mwra_pkg::CFG_ENTRIES_IN_USE: ent_use_q <= cfg_data[4:0];
				mwra_pkg::CFG_RANGES_SUPP:    rng_sup_q <= cfg_data[0];
				mwra_pkg::CFG_WC_SUPP:        wc_sup_q  <= cfg_data[0];
				mwra_pkg::CFG_PHYS_ADDR_BITS: pab_q     <= cfg_data;
				default:                      ent_use_q <= ent_use_q;
			endcase
		end
	end

	// request capture and derived setup words
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			req_q <= req;
		end
		if (cmd.check) begin
			bits_q <= impl_bits(pab_q);
			end_q  <= base64 + 64'(size);
			mask_q <= {16'hFFFF, ~sm1};
		end
		if (cmd.save_slot) begin
			slot_base_q <= rd_b;
			slot_mask_q <= rd_m;
		end
		if (cmd.wr_en) begin
			res_base_q <= new_b;
			res_mask_q <= new_m;
		end
	end

	// entry table, registered read
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			ent_base_q[wa] <= new_b;
			ent_mask_q[wa] <= new_m;
		end
		if (cmd.rd_en) begin
			rd_base_q <= ent_base_q[ra];
			rd_mask_q <= ent_mask_q[ra];
		end
	end

	// written flags of the table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (cmd.wr_en) begin
				vld_q[wa] <= 1'b1;
			end
			if (cmd.rd_en) begin
				rd_vld_q <= vld_q[ra];
			end
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp_q.status         <= cmd.out_status;
			rsp_q.assigned_entry <= cmd.out_entry;
			rsp_q.base_word      <= cmd.out_zero ? '0 : res_base_q;
			rsp_q.mask_word      <= cmd.out_zero ? '0 : res_mask_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// a setup write always leaves the entry valid
	a_setup_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_en && cmd.wr_setup) |=> res_mask_q[mwra_pkg::VALID_BIT])
		else $error("setup wrote an invalid entry");

endmodule

// ----- rtl/mtrr_wc_region_allocator.sv -----
// mtrr_wc_region_allocator: top level of the write-combining range entry allocator
// depends on mwra_pkg, mwra_ctrl and mwra_dp
//
//  channel | signals                           | direction | word
//  --------+-----------------------------------+-----------+---------------------
//  req     | req_valid, req_stall, req         | in        | mwra_pkg::req_word_t
//  rsp     | rsp_valid, rsp_stall, rsp         | out       | mwra_pkg::rsp_word_t
//  cfg     | cfg_we, cfg_index, cfg_data       | in        | write only, no wait
//
// one request at a time; req_stall is low only while the sequencer is idle
// setup: checks, a scan over the active entries, write back, then the response;
//   the scan reads one entry per cycle over the single table read port
// enable, disable, copy: read and write back; bad index or failed check: no write
// reset clears the table flags at once, no clearing pass; config returns to its defaults
// a stalled response holds in the output register while the next request is taken

module mtrr_wc_region_allocator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  mwra_pkg::req_word_t              req,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output mwra_pkg::rsp_word_t              rsp,
	input  logic                             cfg_we,
	input  logic [mwra_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mwra_pkg::CFG_DAT_W-1:0]   cfg_data
);

	mwra_pkg::cmd_t cmd;
	mwra_pkg::sts_t sts;

	// sequencer
	mwra_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// table and arithmetic
	mwra_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// ----- bench/mtrr_wc_region_allocator_tb.sv -----
`timescale 1ns / 1ps
// mtrr_wc_region_allocator_tb: self-checking bench for the write-combining range allocator
// depends on mwra_pkg and mtrr_wc_region_allocator; mirrors the entry table to predict each
// response word and drives requests, stalls and register writes across several settings

module mtrr_wc_region_allocator_tb;

	localparam int CYCLE_LIMIT      = 500000;
	localparam int SETTLE_CYCLES    = 40;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int HOLD_PHASE       = 4;
	localparam int PAUSE_PHASE      = 5;
	localparam int PHASES           = 7;

	// per-phase register settings and word counts
	int unsigned phase_entries [PHASES] = '{8, 8, 0, 31, 16, 1, 8};
	int unsigned phase_ranges  [PHASES] = '{0, 1, 1, 1, 1, 1, 1};
	int unsigned phase_wc      [PHASES] = '{1, 0, 1, 1, 1, 1, 1};
	int unsigned phase_phys    [PHASES] = '{36, 36, 36, 63, 0, 48, 40};
	int unsigned phase_words   [PHASES] = '{60, 60, 60, 250, 250, 120, 250};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	mwra_pkg::req_word_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	mwra_pkg::rsp_word_t rsp;
	logic cfg_we = 1'b0;
	logic [mwra_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [mwra_pkg::CFG_DAT_W-1:0] cfg_data = '0;

	// mirror of the entry table and of the registers
	logic [63:0] tbl_base [mwra_pkg::ENTRY_COUNT] = '{default: '0};
	logic [63:0] tbl_mask [mwra_pkg::ENTRY_COUNT] = '{default: '0};
	logic [4:0] cfg_entries = 5'd8;
	logic cfg_ranges = 1'b1;
	logic cfg_wc = 1'b1;
	logic [5:0] cfg_phys = 6'd36;

	mwra_pkg::req_word_t request_q[$];
	mwra_pkg::rsp_word_t table_answers_q[$];
	int fail_count = 0;
	int phase_no = 0;
	bit last_phase = 1'b0;
	int unsigned cycle_count = 0;

	int unsigned tx_idle_left, tx_run_left;
	int unsigned rx_idle_left, rx_run_left;
	int unsigned long_hold_cnt;
	bit long_hold_done;

	mtrr_wc_region_allocator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock and reset
	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// applies one request word to the mirrored table and returns the response word it gives
	function automatic mwra_pkg::rsp_word_t table_apply(mwra_pkg::req_word_t r);
		mwra_pkg::rsp_word_t o;
		logic [63:0] base, size, bits, rb, rm;
		int unsigned w, lim;
		logic [3:0] slot;
		bit found, hit, in_range;
		o = '0;
		base = {16'd0, r.region_base};
		size = {16'd0, r.region_size};
		found = 1'b0;
		hit = 1'b0;
		slot = 4'd0;
		case (r.op)
			mwra_pkg::OP_SETUP: begin
				if (base < (64'd1 << 20)) o.status = mwra_pkg::ST_BELOW_1M;
				else if (base >= (64'd1 << 36)) o.status = mwra_pkg::ST_ABOVE_36;
				else if (size < (64'd1 << 12)) o.status = mwra_pkg::ST_UNDER_4K;
				else if ((size & (size - 64'd1)) != 0) o.status = mwra_pkg::ST_NOT_POW2;
				else if ((base & (size - 64'd1)) != 0) o.status = mwra_pkg::ST_MISALIGNED;
				else if (!cfg_ranges) o.status = mwra_pkg::ST_UNSUPPORTED;
				else if (!cfg_wc) o.status = mwra_pkg::ST_NO_WC;
				else begin
					// clamp the address width, then scan for overlap and a free entry
					w = 32'(cfg_phys);
					if (w < 36) w = 36;
					if (w > mwra_pkg::ADDR_BITS) w = mwra_pkg::ADDR_BITS;
					bits = ((64'd1 << w) - 64'd1) & ~64'hFFF;
					lim = (32'(cfg_entries) > mwra_pkg::ENTRY_COUNT) ?
						mwra_pkg::ENTRY_COUNT : 32'(cfg_entries);
					for (int i = 0; i < lim; i++) begin
						if (!hit) begin
							if ((tbl_mask[i] & mwra_pkg::VALID_MASK) != 0) begin
								rb = tbl_base[i] & bits;
								rm = tbl_mask[i] & bits;
								if (rb < base + size && rb + (~rm & bits) >= base) hit = 1'b1;
							end else if (!found) begin
								found = 1'b1;
								slot = 4'(i);
							end
						end
					end
					if (hit) o.status = mwra_pkg::ST_OVERLAP;
					else if (!found) o.status = mwra_pkg::ST_NONE_FREE;
					else begin
						tbl_base[slot] = (tbl_base[slot] & ~bits & ~mwra_pkg::TYPE_FIELD)
							| (base & bits) | mwra_pkg::TYPE_WC;
						tbl_mask[slot] = (tbl_mask[slot] & ~bits) | (~(size - 64'd1) & bits)
							| mwra_pkg::VALID_MASK;
						o.status = mwra_pkg::ST_OK;
						o.assigned_entry = slot;
						o.base_word = tbl_base[slot];
						o.mask_word = tbl_mask[slot];
					end
				end
			end
			default: begin
				// direct entry edits always report ok
				o.status = mwra_pkg::ST_OK;
				in_range = (32'(r.entry) < mwra_pkg::ENTRY_COUNT) &&
					(r.op != mwra_pkg::OP_COPY ||
					 32'(r.source_entry) < mwra_pkg::ENTRY_COUNT);
				if (in_range) begin
					if (r.op == mwra_pkg::OP_ENABLE)
						tbl_mask[r.entry] = tbl_mask[r.entry] | mwra_pkg::VALID_MASK;
					else if (r.op == mwra_pkg::OP_DISABLE)
						tbl_mask[r.entry] = tbl_mask[r.entry] & ~mwra_pkg::VALID_MASK;
					else begin
						tbl_base[r.entry] = tbl_base[r.source_entry];
						tbl_mask[r.entry] = tbl_mask[r.source_entry];
					end
					o.base_word = tbl_base[r.entry];
					o.mask_word = tbl_mask[r.entry];
				end
			end
		endcase
		return o;
	endfunction

	// random request word: mostly well-formed setups and entry edits, some broken setups
	function automatic mwra_pkg::req_word_t random_request();
		mwra_pkg::req_word_t r;
		logic [63:0] rnd, size, nblk, lo, base;
		int unsigned pick, k;
		rnd = {$urandom, $urandom};
		r.region_base = rnd[47:0];
		rnd = {$urandom, $urandom};
		r.region_size = rnd[47:0];
		r.entry = 4'($urandom_range(0, 15));
		r.source_entry = 4'($urandom_range(0, 15));
		pick = $urandom_range(0, 99);
		if (pick < 55) r.op = mwra_pkg::OP_SETUP;
		else if (pick < 80) r.op = mwra_pkg::OP_DISABLE;
		else if (pick < 88) r.op = mwra_pkg::OP_ENABLE;
		else r.op = mwra_pkg::OP_COPY;
		if (r.op == mwra_pkg::OP_SETUP) begin
			// aligned power-of-two region inside 1 MB .. 2^36
			if ($urandom_range(0, 9) < 7) k = $urandom_range(12, 20);
			else k = $urandom_range(21, 35);
			size = 64'd1 << k;
			nblk = 64'd1 << (36 - k);
			lo = ((64'd1 << 20) + size - 64'd1) >> k;
			rnd = {$urandom, $urandom};
			base = (lo + rnd % (nblk - lo)) << k;
			if ($urandom_range(0, 99) < 80) begin
				r.region_base = base[47:0];
				r.region_size = size[47:0];
			end else begin
				case ($urandom_range(0, 4))
					0: ;
					1: begin
						r.region_base = base[47:0];
						r.region_size = 48'($urandom_range(0, 4095));
					end
					2: begin
						r.region_base = 48'($urandom_range(0, (1 << 20) - 1));
						r.region_size = size[47:0];
					end
					3: begin
						r.region_base = base[47:0] + size[47:0] / 2;
						r.region_size = size[47:0];
					end
					default: begin
						r.region_base = base[47:0];
						r.region_size = size[47:0] | (size[47:0] >> 1);
					end
				endcase
			end
		end
		return r;
	endfunction

	task automatic push_req(mwra_pkg::op_t op, logic [63:0] base, logic [63:0] size,
		int unsigned dst, int unsigned src);
		mwra_pkg::req_word_t r;
		r.op = op;
		r.region_base = base[47:0];
		r.region_size = size[47:0];
		r.entry = dst[3:0];
		r.source_entry = src[3:0];
		request_q.push_back(r);
	endtask

	task automatic cfg_write(logic [mwra_pkg::CFG_IDX_W-1:0] idx,
		logic [mwra_pkg::CFG_DAT_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			mwra_pkg::CFG_ENTRIES_IN_USE: cfg_entries = val[4:0];
			mwra_pkg::CFG_RANGES_SUPP:    cfg_ranges = val[0];
			mwra_pkg::CFG_WC_SUPP:        cfg_wc = val[0];
			default:                      cfg_phys = val;
		endcase
	endtask

	// wait until every queued word is sent and answered, then let the block settle
	task automatic wait_drained();
		do @(posedge clk);
		while (request_q.size() != 0 || req_valid || table_answers_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// request driver: bursts of gaps, holds a word until it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			tx_idle_left <= 0;
			tx_run_left <= 0;
		end else begin : drive
			bit gap;
			gap = 1'b0;
			if (last_phase) gap = 1'b0;
			else if (tx_idle_left != 0) begin
				gap = 1'b1;
				tx_idle_left <= tx_idle_left - 1;
			end else if (tx_run_left != 0) tx_run_left <= tx_run_left - 1;
			else if ($urandom_range(0, 2) == 0) begin
				gap = 1'b1;
				tx_idle_left <= $urandom_range(0, 17);
			end else tx_run_left <= $urandom_range(0, 59);
			if (req_valid && !req_stall) table_answers_q.push_back(table_apply(req));
			if (!req_valid || !req_stall) begin
				if (!gap && request_q.size() != 0) begin
					req <= request_q.pop_front();
					req_valid <= 1'b1;
				end else req_valid <= 1'b0;
			end
		end
	end

	// response stall: one long hold in its phase, random bursts otherwise
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			rx_idle_left <= 0;
			rx_run_left <= 0;
			long_hold_cnt <= 0;
			long_hold_done <= 1'b0;
		end else if (phase_no == HOLD_PHASE && !long_hold_done) begin
			rsp_stall <= 1'b1;
			long_hold_cnt <= long_hold_cnt + 1;
			if (long_hold_cnt == LONG_HOLD_CYCLES - 1) long_hold_done <= 1'b1;
		end else if (last_phase) rsp_stall <= 1'b0;
		else if (rx_idle_left != 0) begin
			rsp_stall <= 1'b1;
			rx_idle_left <= rx_idle_left - 1;
		end else if (rx_run_left != 0) begin
			rsp_stall <= 1'b0;
			rx_run_left <= rx_run_left - 1;
		end else if ($urandom_range(0, 2) == 0) begin
			rsp_stall <= 1'b1;
			rx_idle_left <= $urandom_range(0, 17);
		end else begin
			rsp_stall <= 1'b0;
			rx_run_left <= $urandom_range(0, 59);
		end
	end

	// response monitor: compare each taken word with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin : check
			mwra_pkg::rsp_word_t want;
			if (table_answers_q.size() == 0) begin
				$error("response word with no request outstanding");
				fail_count++;
			end else begin
				want = table_answers_q.pop_front();
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp.status);
					fail_count++;
				end
				if (rsp.assigned_entry !== want.assigned_entry) begin
					$error("assigned_entry: expected %0d, got %0d", want.assigned_entry,
						rsp.assigned_entry);
					fail_count++;
				end
				if (rsp.base_word !== want.base_word) begin
					$error("base_word: expected %h, got %h", want.base_word, rsp.base_word);
					fail_count++;
				end
				if (rsp.mask_word !== want.mask_word) begin
					$error("mask_word: expected %h, got %h", want.mask_word, rsp.mask_word);
					fail_count++;
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// stimulus sequence
	initial begin
		@(posedge arst_n);
		repeat (2) @(posedge clk);

		// directed words under reset settings
		push_req(mwra_pkg::OP_SETUP, 64'h0, 64'h1000, 0, 0);
		push_req(mwra_pkg::OP_SETUP, 64'h10_0000_0000, 64'h1000, 0, 0);
		push_req(mwra_pkg::OP_SETUP, 64'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF, 15, 15);
		push_req(mwra_pkg::OP_SETUP, 64'h10_0000, 64'h0, 0, 0);
		push_req(mwra_pkg::OP_SETUP, 64'h10_0000, 64'hFFF, 0, 0);
		push_req(mwra_pkg::OP_SETUP, 64'h10_0000, 64'h3000, 0, 0);
		push_req(mwra_pkg::OP_SETUP, 64'h10_1000, 64'h2000, 0, 0);
		push_req(mwra_pkg::OP_SETUP, 64'h10_0000, 64'h1000, 0, 0);
		push_req(mwra_pkg::OP_SETUP, 64'h10_0000, 64'h1000, 0, 0);
		push_req(mwra_pkg::OP_SETUP, 64'hF_FFFF_F000, 64'h1000, 0, 0);
		push_req(mwra_pkg::OP_SETUP, 64'h8_0000_0000, 64'h8_0000_0000, 0, 0);
		push_req(mwra_pkg::OP_ENABLE, 64'h0, 64'h0, 15, 0);
		push_req(mwra_pkg::OP_DISABLE, 64'h0, 64'h0, 15, 0);
		push_req(mwra_pkg::OP_COPY, 64'h0, 64'h0, 15, 0);
		push_req(mwra_pkg::OP_COPY, 64'h0, 64'h0, 0, 15);
		push_req(mwra_pkg::OP_DISABLE, 64'h0, 64'h0, 0, 0);
		push_req(mwra_pkg::OP_DISABLE, 64'h0, 64'h0, 1, 0);
		push_req(mwra_pkg::OP_SETUP, 64'h10_0000, 64'h10_0000, 0, 0);
		// a never-written entry made valid covers every address
		push_req(mwra_pkg::OP_ENABLE, 64'h0, 64'h0, 2, 0);
		push_req(mwra_pkg::OP_SETUP, 64'h20_0000, 64'h10_0000, 0, 0);
		push_req(mwra_pkg::OP_DISABLE, 64'h0, 64'h0, 2, 0);
		push_req(mwra_pkg::OP_SETUP, 64'h20_0000, 64'h10_0000, 0, 0);
		push_req(mwra_pkg::OP_COPY, 64'h0, 64'h0, 0, 0);
		wait_drained();

		// random phases over several register settings
		for (int p = 0; p < PHASES; p++) begin
			cfg_write(mwra_pkg::CFG_ENTRIES_IN_USE, mwra_pkg::CFG_DAT_W'(phase_entries[p]));
			cfg_write(mwra_pkg::CFG_RANGES_SUPP, mwra_pkg::CFG_DAT_W'(phase_ranges[p]));
			cfg_write(mwra_pkg::CFG_WC_SUPP, mwra_pkg::CFG_DAT_W'(phase_wc[p]));
			cfg_write(mwra_pkg::CFG_PHYS_ADDR_BITS, mwra_pkg::CFG_DAT_W'(phase_phys[p]));
			last_phase = (p == PHASES - 1);
			phase_no = p + 1;
			for (int n = 0; n < int'(phase_words[p]); n++) begin
				request_q.push_back(random_request());
				// sender pause halfway through its phase
				if (phase_no == PAUSE_PHASE && n == int'(phase_words[p] / 2)) wait_drained();
			end
			wait_drained();
		end

		if (fail_count == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/mwra_pkg.sv
rtl/mwra_ctrl.sv
rtl/mwra_dp.sv
rtl/mtrr_wc_region_allocator.sv
bench/mtrr_wc_region_allocator_tb.sv
